>>> hw/rtl/pgst_pkg.sv
// Shared types and constants of the packed group segment table.
package pgst_pkg;

   localparam int DEF_MAX_GROUPS   = 128;
   localparam int DEF_BUFFER_DEPTH = 512;
   localparam int DEF_NUM_SAMPLES  = 2048;

   localparam int MAP_W    = 8;
   localparam int SAMPLE_W = 11;
   localparam int GROUP_W  = 7;
   localparam int INDEX_W  = 9;
   localparam int TOTAL_W  = 10;
   localparam int STATUS_W = 2;

   localparam logic [MAP_W-1:0] NO_GROUP = 8'hFF;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      OP_MAKE          = 3'd0,
      OP_ADD           = 3'd1,
      OP_REMOVE_SAMPLE = 3'd2,
      OP_REMOVE_GROUP  = 3'd3,
      OP_MEMBER        = 3'd4,
      OP_COUNT         = 3'd5,
      OP_BY_INDEX      = 3'd6,
      OP_MOVE_END      = 3'd7
   } op_type;

   typedef enum logic [4:0] {
      C_NONE, C_CLEAR, C_ACCEPT, C_LOOKUP, C_RES_FULL, C_RES_NF, C_MAKE, C_ADD_FIN,
      C_SCAN_INIT, C_SCAN_RD, C_SCAN_HIT, C_SCAN_NEXT, C_SHIFT_INIT, C_SHIFT_RD,
      C_SHIFT_WR, C_CNT_CLR, C_SAVE_RD, C_SAVE_WR, C_REST_RD, C_REST_WR, C_GS_RD,
      C_GS_WR, C_GS_END, C_MS_RD, C_MS_WR, C_IDX_RD, C_IDX_CAP, C_RESPOND
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_CMP, ST_SHIFT_RD,
      ST_SHIFT_WR, ST_SAVE_RD, ST_SAVE_WR, ST_REST_RD, ST_REST_WR, ST_GS_RD, ST_GS_WR,
      ST_ADD_FIN, ST_MS_RD, ST_MS_WR, ST_IDX_CAP, ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
      logic   valid;
      logic   make_full;
      logic   buf_full;
      logic   need_move;
      logic   idx_ok;
      logic   scan_end;
      logic   match;
      logic   shift_end;
      logic   cnt_ge_len;
      logic   gs_end;
      logic   ms_end;
      logic   clear_last;
   } dp_flags_type;

endpackage

>>> hw/rtl/pgst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pgst_ctrl.sv
// Sequencer of the packed group segment table.
module pgst_ctrl
   import pgst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_flags_type flags,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = C_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = C_CLEAR;
            if (flags.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd      = C_ACCEPT;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd      = C_LOOKUP;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            unique case (flags.op)
               OP_MAKE: cmd = flags.make_full ? C_RES_FULL : C_MAKE;
               OP_ADD: begin
                  if (!flags.valid) begin
                     cmd = C_NONE;
                  end else if (flags.buf_full) begin
                     cmd = C_RES_FULL;
                  end else if (flags.need_move) begin
                     cmd      = C_CNT_CLR;
                     state_in = ST_SAVE_RD;
                  end else begin
                     cmd = C_ADD_FIN;
                  end
               end
               OP_REMOVE_SAMPLE, OP_MEMBER: begin
                  cmd      = C_SCAN_INIT;
                  state_in = ST_SCAN_RD;
               end
               OP_REMOVE_GROUP: begin
                  if (flags.valid) begin
                     cmd      = C_SHIFT_INIT;
                     state_in = ST_SHIFT_RD;
                  end
               end
               OP_COUNT: cmd = C_NONE;
               OP_BY_INDEX: begin
                  if (flags.idx_ok) begin
                     cmd      = C_IDX_RD;
                     state_in = ST_IDX_CAP;
                  end else begin
                     cmd = C_RES_NF;
                  end
               end
               OP_MOVE_END: begin
                  if (flags.valid && flags.need_move) begin
                     cmd      = C_CNT_CLR;
                     state_in = ST_SAVE_RD;
                  end
               end
               default: cmd = C_NONE;
            endcase
         end
         ST_SCAN_RD: begin
            if (flags.scan_end) begin
               cmd      = (flags.op == OP_REMOVE_SAMPLE) ? C_RES_NF : C_NONE;
               state_in = ST_DONE;
            end else begin
               cmd      = C_SCAN_RD;
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (flags.match) begin
               cmd      = C_SCAN_HIT;
               state_in = (flags.op == OP_REMOVE_SAMPLE) ? ST_SHIFT_RD : ST_DONE;
            end else begin
               cmd      = C_SCAN_NEXT;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (flags.shift_end) begin
               cmd = C_CNT_CLR;
               if (flags.op == OP_REMOVE_SAMPLE || flags.op == OP_REMOVE_GROUP) begin
                  state_in = ST_GS_RD;
               end else begin
                  state_in = ST_REST_RD;
               end
            end else begin
               cmd      = C_SHIFT_RD;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd      = C_SHIFT_WR;
            state_in = ST_SHIFT_RD;
         end
         ST_SAVE_RD: begin
            if (flags.cnt_ge_len) begin
               cmd      = C_SHIFT_INIT;
               state_in = ST_SHIFT_RD;
            end else begin
               cmd      = C_SAVE_RD;
               state_in = ST_SAVE_WR;
            end
         end
         ST_SAVE_WR: begin
            cmd      = C_SAVE_WR;
            state_in = ST_SAVE_RD;
         end
         ST_REST_RD: begin
            if (flags.cnt_ge_len) begin
               cmd      = C_CNT_CLR;
               state_in = ST_GS_RD;
            end else begin
               cmd      = C_REST_RD;
               state_in = ST_REST_WR;
            end
         end
         ST_REST_WR: begin
            cmd      = C_REST_WR;
            state_in = ST_REST_RD;
         end
         ST_GS_RD: begin
            if (flags.gs_end) begin
               cmd = C_GS_END;
               if (flags.op == OP_ADD) begin
                  state_in = ST_ADD_FIN;
               end else if (flags.op == OP_REMOVE_GROUP) begin
                  state_in = ST_MS_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd      = C_GS_RD;
               state_in = ST_GS_WR;
            end
         end
         ST_GS_WR: begin
            cmd      = C_GS_WR;
            state_in = ST_GS_RD;
         end
         ST_ADD_FIN: begin
            cmd      = C_ADD_FIN;
            state_in = ST_DONE;
         end
         ST_MS_RD: begin
            if (flags.ms_end) begin
               state_in = ST_DONE;
            end else begin
               cmd      = C_MS_RD;
               state_in = ST_MS_WR;
            end
         end
         ST_MS_WR: begin
            cmd      = C_MS_WR;
            state_in = ST_MS_RD;
         end
         ST_IDX_CAP: begin
            cmd      = C_IDX_CAP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd      = C_RESPOND;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_accept_when_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_ACCEPT) |-> (state_ff == ST_IDLE && start))
      else $error("transaction accepted outside idle");

   a_lookup_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_ACCEPT) |=> (cmd == C_LOOKUP))
      else $error("lookup missing after accept");

   a_respond_then_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == C_RESPOND) |=> !busy)
      else $error("not idle after response");

endmodule

>>> hw/rtl/pgst_dp.sv
// Datapath of the packed group segment table: tables, buffer, map and counters.
module pgst_dp
   import pgst_pkg::*;
#(
   parameter int MAX_GROUPS   = DEF_MAX_GROUPS,
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
   parameter int NUM_SAMPLES  = DEF_NUM_SAMPLES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output dp_flags_type        flags,
   input  logic [2:0]          req_type,
   input  logic [GROUP_W-1:0]  req_group_id,
   input  logic [SAMPLE_W-1:0] req_sample_id,
   input  logic [INDEX_W-1:0]  req_member_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GROUP_W-1:0]  rsp_new_group,
   output logic [SAMPLE_W-1:0] rsp_member_sample,
   output logic [TOTAL_W-1:0]  rsp_member_total,
   output logic                rsp_is_member
);

   localparam int AW   = $clog2(BUFFER_DEPTH);
   localparam int LW   = AW + 1;
   localparam int TAW  = $clog2(MAX_GROUPS);
   localparam int GCW  = $clog2(MAX_GROUPS + 1);
   localparam int SAW  = $clog2(NUM_SAMPLES);
   localparam int TW   = AW + LW;
   localparam int MAXA = (NUM_SAMPLES > BUFFER_DEPTH) ? NUM_SAMPLES : BUFFER_DEPTH;
   localparam int MAXB = (MAXA > MAX_GROUPS) ? MAXA : MAX_GROUPS;
   localparam int CW   = $clog2(MAXB + 1) + 1;

   op_type              op_ff, op_in;
   logic [GROUP_W-1:0]  g_ff, g_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [AW-1:0]       s_ff, s_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [AW-1:0]       fin_start_ff, fin_start_in;
   logic [LW-1:0]       k_ff, k_in;
   logic [GCW-1:0]      grp_cnt_ff, grp_cnt_in;
   logic [LW-1:0]       mem_cnt_ff, mem_cnt_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [GROUP_W-1:0]  new_group_ff, new_group_in;
   logic [SAMPLE_W-1:0] member_ff, member_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                is_mem_ff, is_mem_in;

   logic                tbl_we;
   logic [TAW-1:0]      tbl_wa, tbl_ra;
   logic [TW-1:0]       tbl_wd, tbl_rd;
   logic                buf_we;
   logic [AW-1:0]       buf_wa, buf_ra;
   logic [SAMPLE_W-1:0] buf_wd, buf_rd;
   logic                scr_we;
   logic [AW-1:0]       scr_wa, scr_ra;
   logic [SAMPLE_W-1:0] scr_wd, scr_rd;
   logic                map_we;
   logic [SAW-1:0]      map_wa, map_ra;
   logic [MAP_W-1:0]    map_wd, map_rd;

   logic [AW-1:0]       tbl_start;
   logic [LW-1:0]       tbl_len;
   logic [CW-1:0]       s_w, len_w, n_w, k_w, g_w, gc_w, hs_w, end_w;
   logic                in_range, lk_valid;
   logic [MAP_W-1:0]    g_map;
   logic [AW-1:0]       hs_new;

   assign tbl_start = tbl_rd[TW-1:LW];
   assign tbl_len   = tbl_rd[LW-1:0];
   assign s_w       = CW'(s_ff);
   assign len_w     = CW'(len_ff);
   assign n_w       = CW'(mem_cnt_ff);
   assign k_w       = CW'(k_ff);
   assign g_w       = CW'(g_ff);
   assign gc_w      = CW'(grp_cnt_ff);
   assign hs_w      = CW'(tbl_start);
   assign end_w     = s_w + len_w;
   assign in_range  = CW'(sample_ff) < CW'(NUM_SAMPLES);
   assign lk_valid  = g_w < gc_w;
   assign g_map     = MAP_W'(g_ff);

   assign flags.op         = op_ff;
   assign flags.valid      = valid_ff;
   assign flags.make_full  = (gc_w >= CW'(MAX_GROUPS)) || (n_w >= CW'(BUFFER_DEPTH));
   assign flags.buf_full   = n_w >= CW'(BUFFER_DEPTH);
   assign flags.need_move  = end_w < n_w;
   assign flags.idx_ok     = CW'(idx_ff) < len_w;
   assign flags.scan_end   = cnt_ff >= end_w;
   assign flags.match      = buf_rd == sample_ff;
   assign flags.shift_end  = (cnt_ff + k_w) >= n_w;
   assign flags.cnt_ge_len = cnt_ff >= len_w;
   assign flags.gs_end     = cnt_ff >= gc_w;
   assign flags.ms_end     = cnt_ff >= CW'(NUM_SAMPLES);
   assign flags.clear_last = cnt_ff == CW'(NUM_SAMPLES - 1);

   always_comb begin
      op_in        = op_ff;
      g_in         = g_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      s_in         = s_ff;
      len_in       = len_ff;
      fin_start_in = fin_start_ff;
      k_in         = k_ff;
      grp_cnt_in   = grp_cnt_ff;
      mem_cnt_in   = mem_cnt_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      new_group_in = new_group_ff;
      member_in    = member_ff;
      total_in     = total_ff;
      is_mem_in    = is_mem_ff;
      tbl_we = 1'b0;  tbl_wa = '0;  tbl_wd = '0;  tbl_ra = '0;
      buf_we = 1'b0;  buf_wa = '0;  buf_wd = '0;  buf_ra = '0;
      scr_we = 1'b0;  scr_wa = '0;  scr_wd = '0;  scr_ra = '0;
      map_we = 1'b0;  map_wa = '0;  map_wd = '0;  map_ra = '0;
      hs_new = tbl_start;
      unique case (cmd)
         C_CLEAR: begin
            map_we = 1'b1;
            map_wa = SAW'(cnt_ff);
            map_wd = NO_GROUP;
            cnt_in = flags.clear_last ? '0 : cnt_ff + 1'b1;
         end
         C_ACCEPT: begin
            op_in     = op_type'(req_type);
            g_in      = req_group_id;
            sample_in = req_sample_id;
            idx_in    = req_member_index;
            tbl_ra    = TAW'(req_group_id);
         end
         C_LOOKUP: begin
            valid_in     = lk_valid;
            s_in         = lk_valid ? tbl_start : '0;
            len_in       = lk_valid ? tbl_len : '0;
            fin_start_in = lk_valid ? tbl_start : '0;
            status_in    = STAT_OK;
            new_group_in = '0;
            member_in    = '0;
            is_mem_in    = 1'b0;
            if (op_ff == OP_MAKE || op_ff == OP_REMOVE_GROUP || !lk_valid) begin
               total_in = '0;
            end else begin
               total_in = TOTAL_W'(tbl_len);
            end
         end
         C_RES_FULL: status_in = STAT_FULL;
         C_RES_NF:   status_in = STAT_NOT_FOUND;
         C_MAKE: begin
            tbl_we       = 1'b1;
            tbl_wa       = TAW'(grp_cnt_ff);
            tbl_wd       = {AW'(mem_cnt_ff), LW'(1)};
            buf_we       = 1'b1;
            buf_wa       = AW'(mem_cnt_ff);
            buf_wd       = sample_ff;
            map_we       = in_range;
            map_wa       = SAW'(sample_ff);
            map_wd       = MAP_W'(grp_cnt_ff);
            mem_cnt_in   = mem_cnt_ff + 1'b1;
            grp_cnt_in   = grp_cnt_ff + 1'b1;
            new_group_in = GROUP_W'(grp_cnt_ff);
            total_in     = TOTAL_W'(1);
         end
         C_ADD_FIN: begin
            tbl_we     = 1'b1;
            tbl_wa     = TAW'(g_ff);
            tbl_wd     = {fin_start_ff, LW'(len_ff + 1'b1)};
            buf_we     = 1'b1;
            buf_wa     = AW'(mem_cnt_ff);
            buf_wd     = sample_ff;
            map_we     = in_range;
            map_wa     = SAW'(sample_ff);
            map_wd     = g_map;
            mem_cnt_in = mem_cnt_ff + 1'b1;
            total_in   = TOTAL_W'(len_ff + 1'b1);
         end
         C_SCAN_INIT: cnt_in = s_w;
         C_SCAN_RD:   buf_ra = AW'(cnt_ff);
         C_SCAN_HIT: begin
            is_mem_in = (op_ff == OP_MEMBER);
            k_in      = LW'(1);
         end
         C_SCAN_NEXT: cnt_in = cnt_ff + 1'b1;
         C_SHIFT_INIT: begin
            cnt_in = s_w;
            k_in   = len_ff;
         end
         C_SHIFT_RD: buf_ra = AW'(cnt_ff + k_w);
         C_SHIFT_WR: begin
            buf_we = 1'b1;
            buf_wa = AW'(cnt_ff);
            buf_wd = buf_rd;
            cnt_in = cnt_ff + 1'b1;
         end
         C_CNT_CLR: cnt_in = '0;
         C_SAVE_RD: buf_ra = AW'(s_w + cnt_ff);
         C_SAVE_WR: begin
            scr_we = 1'b1;
            scr_wa = AW'(cnt_ff);
            scr_wd = buf_rd;
            cnt_in = cnt_ff + 1'b1;
         end
         C_REST_RD: scr_ra = AW'(cnt_ff);
         C_REST_WR: begin
            buf_we = 1'b1;
            buf_wa = AW'(n_w - len_w + cnt_ff);
            buf_wd = scr_rd;
            cnt_in = cnt_ff + 1'b1;
         end
         C_GS_RD: tbl_ra = TAW'(cnt_ff);
         C_GS_WR: begin
            tbl_we = 1'b1;
            tbl_wa = TAW'(cnt_ff);
            priority if (op_ff == OP_REMOVE_SAMPLE) begin
               if (hs_w > end_w - 1'b1) hs_new = AW'(hs_w - 1'b1);
               if (cnt_ff == g_w) begin
                  tbl_wd = {s_ff, LW'(len_ff - 1'b1)};
               end else begin
                  tbl_wd = {hs_new, tbl_len};
               end
            end else if (op_ff == OP_REMOVE_GROUP) begin
               if (hs_w > s_w) hs_new = AW'(hs_w - len_w);
               tbl_we = (cnt_ff != g_w);
               if (cnt_ff > g_w) tbl_wa = TAW'(cnt_ff - 1'b1);
               tbl_wd = {hs_new, tbl_len};
            end else begin
               if (hs_w > s_w) hs_new = AW'(hs_w - len_w);
               if (cnt_ff == g_w) begin
                  tbl_wd = {AW'(n_w - len_w), len_ff};
               end else begin
                  tbl_wd = {hs_new, tbl_len};
               end
            end
            cnt_in = cnt_ff + 1'b1;
         end
         C_GS_END: begin
            cnt_in = '0;
            priority if (op_ff == OP_REMOVE_SAMPLE) begin
               mem_cnt_in = mem_cnt_ff - 1'b1;
               total_in   = TOTAL_W'(len_ff - 1'b1);
            end else if (op_ff == OP_REMOVE_GROUP) begin
               mem_cnt_in = mem_cnt_ff - len_ff;
               grp_cnt_in = grp_cnt_ff - 1'b1;
            end else begin
               fin_start_in = AW'(n_w - len_w);
            end
         end
         C_MS_RD: map_ra = SAW'(cnt_ff);
         C_MS_WR: begin
            map_we = 1'b1;
            map_wa = SAW'(cnt_ff);
            priority if (map_rd == NO_GROUP) begin
               map_wd = map_rd;
            end else if (map_rd == g_map) begin
               map_wd = NO_GROUP;
            end else if (map_rd > g_map) begin
               map_wd = map_rd - 1'b1;
            end else begin
               map_wd = map_rd;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         C_IDX_RD:  buf_ra = AW'(s_w + CW'(idx_ff));
         C_IDX_CAP: member_in = buf_rd;
         C_RESPOND: rsp_valid_in = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff   <= '0;
         mem_cnt_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_cnt_ff   <= grp_cnt_in;
         mem_cnt_ff   <= mem_cnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      g_ff         <= g_in;
      sample_ff    <= sample_in;
      idx_ff       <= idx_in;
      valid_ff     <= valid_in;
      s_ff         <= s_in;
      len_ff       <= len_in;
      fin_start_ff <= fin_start_in;
      k_ff         <= k_in;
      status_ff    <= status_in;
      new_group_ff <= new_group_in;
      member_ff    <= member_in;
      total_ff     <= total_in;
      is_mem_ff    <= is_mem_in;
   end

   pgst_ram #(.WIDTH(TW), .DEPTH(MAX_GROUPS)) u_tbl (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_wa), .wr_data(tbl_wd),
      .rd_addr(tbl_ra), .rd_data(tbl_rd)
   );

   pgst_ram #(.WIDTH(SAMPLE_W), .DEPTH(BUFFER_DEPTH)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_wa), .wr_data(buf_wd),
      .rd_addr(buf_ra), .rd_data(buf_rd)
   );

   pgst_ram #(.WIDTH(SAMPLE_W), .DEPTH(BUFFER_DEPTH)) u_scr (
      .clock(clock), .wr_en(scr_we), .wr_addr(scr_wa), .wr_data(scr_wd),
      .rd_addr(scr_ra), .rd_data(scr_rd)
   );

   pgst_ram #(.WIDTH(MAP_W), .DEPTH(NUM_SAMPLES)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_new_group     = new_group_ff;
   assign rsp_member_sample = member_ff;
   assign rsp_member_total  = total_ff;
   assign rsp_is_member     = is_mem_ff;

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(mem_cnt_ff) <= CW'(BUFFER_DEPTH))
      else $error("buffer fill above depth");

   a_grp_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(grp_cnt_ff) <= CW'(MAX_GROUPS))
      else $error("group count above limit");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response held longer than one cycle");

endmodule

>>> hw/rtl/packed_group_segment_table.sv
// Packed group segment table: top level.
//
// Groups of sample ids live as contiguous segments of one packed buffer; a
// per-sample map records each sample's group. A request is a transaction taken
// at a rising edge with start high and busy low; req_type selects make, add,
// remove sample, remove group, membership test, count, member by index or
// move to end. Each request yields exactly one response, shown on the rsp_
// ports for one cycle with rsp_valid high; the receiver cannot stall it.
// Counts and failed lookups answer from the group table; a read by index adds
// a buffer read; membership tests compare the segment member by member up to
// the first hit. Add and move to end, when the segment is not last, copy it
// out, close the gap and copy it back, then pass over the group table. Remove
// sample scans for the sample, closes the gap and passes over the group table.
// Each entry moved through the buffer passes a read state, then a write state.
// Remove group closes the gap, passes over the group table, then sweeps the
// sample map, clearing the group's entries and renumbering higher groups. One
// request is handled at a time; busy stays high until its response is shown.
// With busy high after reset, the map is set to "no group" one entry per cycle.
module packed_group_segment_table
   import pgst_pkg::*;
#(
   parameter int MAX_GROUPS   = DEF_MAX_GROUPS,
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
   parameter int NUM_SAMPLES  = DEF_NUM_SAMPLES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_type,
   input  logic [GROUP_W-1:0]  req_group_id,
   input  logic [SAMPLE_W-1:0] req_sample_id,
   input  logic [INDEX_W-1:0]  req_member_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GROUP_W-1:0]  rsp_new_group,
   output logic [SAMPLE_W-1:0] rsp_member_sample,
   output logic [TOTAL_W-1:0]  rsp_member_total,
   output logic                rsp_is_member
);

   cmd_type      cmd;
   dp_flags_type flags;

   pgst_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .flags(flags),
      .cmd(cmd)
   );

   pgst_dp #(
      .MAX_GROUPS(MAX_GROUPS),
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .NUM_SAMPLES(NUM_SAMPLES)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .flags(flags),
      .req_type(req_type),
      .req_group_id(req_group_id),
      .req_sample_id(req_sample_id),
      .req_member_index(req_member_index),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_new_group(rsp_new_group),
      .rsp_member_sample(rsp_member_sample),
      .rsp_member_total(rsp_member_total),
      .rsp_is_member(rsp_is_member)
   );

endmodule

>>> bench/packed_group_segment_table_tb.sv
// Testbench for the packed group segment table: directed, random and full-table tests.
`timescale 1ns / 1ps

module packed_group_segment_table_tb;
   import pgst_pkg::*;

   localparam int NGROUPS    = DEF_MAX_GROUPS;
   localparam int NDEPTH     = DEF_BUFFER_DEPTH;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GROUP_W-1:0]  new_group;
      logic [SAMPLE_W-1:0] member_sample;
      logic [TOTAL_W-1:0]  total;
      logic                is_member;
   } table_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_type = '0;
   logic [GROUP_W-1:0]  req_group_id = '0;
   logic [SAMPLE_W-1:0] req_sample_id = '0;
   logic [INDEX_W-1:0]  req_member_index = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [GROUP_W-1:0]  rsp_new_group;
   logic [SAMPLE_W-1:0] rsp_member_sample;
   logic [TOTAL_W-1:0]  rsp_member_total;
   logic                rsp_is_member;

   int seg_start [NGROUPS];
   int seg_len [NGROUPS];
   int packed_ids [NDEPTH];
   int group_count = 0;
   int member_count = 0;

   table_rsp_type pending_rsp [$];
   int mismatches = 0;
   int txn_count = 0;
   int rsp_count = 0;
   int cycles = 0;
   int op_seen [8];

   packed_group_segment_table i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_group_id(req_group_id), .req_sample_id(req_sample_id),
      .req_member_index(req_member_index), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_new_group(rsp_new_group), .rsp_member_sample(rsp_member_sample),
      .rsp_member_total(rsp_member_total), .rsp_is_member(rsp_is_member)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic void move_seg_to_end(int g);
      int s, len, n, i, h;
      int hold [NDEPTH];
      s = seg_start[g];
      len = seg_len[g];
      n = member_count;
      if (s + len >= n) return;
      for (i = 0; i < len; i++) hold[i] = packed_ids[s + i];
      for (i = s; i + len < n; i++) packed_ids[i] = packed_ids[i + len];
      for (i = 0; i < len; i++) packed_ids[n - len + i] = hold[i];
      for (h = 0; h < group_count; h++)
         if (h != g && seg_start[h] > s) seg_start[h] -= len;
      seg_start[g] = n - len;
   endfunction

   function automatic table_rsp_type apply_request(op_type op, int g, int smp, int idx);
      table_rsp_type r;
      bit ok;
      int s, len, i, h, hit;
      r = '0;
      ok = g < group_count;
      s = ok ? seg_start[g] : 0;
      len = ok ? seg_len[g] : 0;
      case (op)
         OP_MAKE: begin
            if (group_count >= NGROUPS || member_count >= NDEPTH) begin
               r.status = STAT_FULL;
            end else begin
               seg_start[group_count] = member_count;
               seg_len[group_count] = 1;
               packed_ids[member_count] = smp;
               member_count++;
               r.new_group = GROUP_W'(group_count);
               group_count++;
               r.total = TOTAL_W'(1);
            end
         end
         OP_ADD: begin
            if (ok) begin
               if (member_count >= NDEPTH) begin
                  r.status = STAT_FULL;
                  r.total = TOTAL_W'(len);
               end else begin
                  move_seg_to_end(g);
                  packed_ids[member_count] = smp;
                  member_count++;
                  seg_len[g] = len + 1;
                  r.total = TOTAL_W'(len + 1);
               end
            end
         end
         OP_REMOVE_SAMPLE: begin
            hit = -1;
            for (i = s; i < s + len; i++)
               if (hit < 0 && packed_ids[i] == smp) hit = i;
            if (hit < 0) begin
               r.status = STAT_NOT_FOUND;
               r.total = TOTAL_W'(len);
            end else begin
               for (i = hit; i + 1 < member_count; i++) packed_ids[i] = packed_ids[i + 1];
               member_count--;
               seg_len[g] = len - 1;
               for (h = 0; h < group_count; h++)
                  if (h != g && seg_start[h] > s + len - 1) seg_start[h]--;
               r.total = TOTAL_W'(len - 1);
            end
         end
         OP_REMOVE_GROUP: begin
            if (ok) begin
               for (i = s; i + len < member_count; i++) packed_ids[i] = packed_ids[i + len];
               member_count -= len;
               for (h = 0; h < group_count; h++)
                  if (h != g && seg_start[h] > s) seg_start[h] -= len;
               for (h = g; h + 1 < group_count; h++) begin
                  seg_start[h] = seg_start[h + 1];
                  seg_len[h] = seg_len[h + 1];
               end
               group_count--;
            end
         end
         OP_MEMBER: begin
            for (i = s; i < s + len; i++)
               if (packed_ids[i] == smp) r.is_member = 1'b1;
            r.total = TOTAL_W'(len);
         end
         OP_COUNT: r.total = TOTAL_W'(len);
         OP_BY_INDEX: begin
            if (idx < len) r.member_sample = SAMPLE_W'(packed_ids[s + idx]);
            else r.status = STAT_NOT_FOUND;
            r.total = TOTAL_W'(len);
         end
         default: begin
            if (ok) move_seg_to_end(g);
            r.total = TOTAL_W'(len);
         end
      endcase
      return r;
   endfunction

   task automatic send_txn(op_type op, int g, int smp, int idx);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= op;
      req_group_id <= GROUP_W'(g);
      req_sample_id <= SAMPLE_W'(smp);
      req_member_index <= INDEX_W'(idx);
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_request(op, g, smp, idx));
      op_seen[op]++;
      txn_count++;
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      table_rsp_type exp_rsp, got;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_new_group, rsp_member_sample, rsp_member_total,
                 rsp_is_member};
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (got !== exp_rsp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d mismatch: expected %p, got %p",
                           rsp_count, exp_rsp, got);
            end
         end
      end
   end

   task automatic test_directed_ops();
      send_txn(OP_MAKE, 0, 0, 0);
      send_txn(OP_MAKE, 127, 2047, 511);
      send_txn(OP_MAKE, 0, 1365, 0);
      send_txn(OP_ADD, 0, 682, 0);
      send_txn(OP_ADD, 1, 2047, 0);
      send_txn(OP_ADD, 0, 682, 0);
      send_txn(OP_ADD, 2, 4000 % 2048, 0);
      send_txn(OP_ADD, 127, 5, 0);
      send_txn(OP_MEMBER, 0, 682, 0);
      send_txn(OP_MEMBER, 0, 2047, 0);
      send_txn(OP_MEMBER, 127, 0, 0);
      send_txn(OP_COUNT, 1, 0, 0);
      send_txn(OP_COUNT, 127, 0, 0);
      send_txn(OP_BY_INDEX, 0, 0, 2);
      send_txn(OP_BY_INDEX, 0, 0, 511);
      send_txn(OP_BY_INDEX, 127, 0, 0);
      send_txn(OP_REMOVE_SAMPLE, 0, 682, 0);
      send_txn(OP_REMOVE_SAMPLE, 0, 999, 0);
      send_txn(OP_REMOVE_SAMPLE, 127, 0, 0);
      send_txn(OP_MOVE_END, 1, 0, 0);
      send_txn(OP_MOVE_END, 1, 0, 0);
      send_txn(OP_REMOVE_GROUP, 127, 0, 0);
      send_txn(OP_REMOVE_GROUP, 1, 0, 0);
      send_txn(OP_BY_INDEX, 1, 0, 0);
   endtask

   task automatic test_random_traffic(int n);
      int k, pick, g, smp, idx, len;
      op_type op;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) op = OP_MAKE;
         else if (pick < 45) op = OP_ADD;
         else if (pick < 60) op = OP_REMOVE_SAMPLE;
         else if (pick < 64) op = OP_REMOVE_GROUP;
         else if (pick < 74) op = OP_MEMBER;
         else if (pick < 79) op = OP_COUNT;
         else if (pick < 90) op = OP_BY_INDEX;
         else op = OP_MOVE_END;
         if ($urandom_range(0, 9) == 0) g = $urandom_range(0, 127);
         else g = $urandom_range(0, group_count);
         len = (g < group_count) ? seg_len[g] : 0;
         if ($urandom_range(0, 2) == 0) smp = $urandom_range(0, 2047);
         else smp = $urandom_range(0, 15);
         if ((op == OP_REMOVE_SAMPLE || op == OP_MEMBER) && len > 0 && $urandom_range(0, 3) != 0)
            smp = packed_ids[seg_start[g] + $urandom_range(0, len - 1)];
         if ($urandom_range(0, 4) == 0) idx = $urandom_range(0, 511);
         else idx = $urandom_range(0, len);
         send_txn(op, g, smp, idx);
      end
   endtask

   task automatic test_table_full();
      while (group_count < NGROUPS && member_count < NDEPTH)
         send_txn(OP_MAKE, 0, $urandom_range(0, 2047), 0);
      send_txn(OP_MAKE, 0, 3, 0);
      send_txn(OP_ADD, group_count - 1, 7, 0);
      send_txn(OP_ADD, 0, 9, 0);
      send_txn(OP_MAKE, 0, 11, 0);
      send_txn(OP_BY_INDEX, group_count - 1, 0, 300);
      send_txn(OP_REMOVE_GROUP, group_count - 1, 0, 0);
      send_txn(OP_COUNT, group_count - 1, 0, 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      wait_drain();
      test_random_traffic(75);
      wait_drain();
      test_random_traffic(75);
      test_table_full();
      wait_drain();
      repeat (20) @(posedge clock);
      $display("covered %0d transactions, %0d responses, %0d cycles", txn_count, rsp_count,
               cycles);
      $display("per operation: %p, mismatches %0d", op_seen, mismatches);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
